/* rtl/polyline_nearest_distance_defines.svh */
// assertion macros for the polyline nearest distance block
// used by the top level; expects clk and rst_n in scope
`ifndef POLYLINE_NEAREST_DISTANCE_DEFINES_SVH
`define POLYLINE_NEAREST_DISTANCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PND_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnd assertion failed");
`define PND_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnd assertion failed");
`else
`define PND_ASSERT_SAME(label, ante, cons)
`define PND_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/pnd_pkg.sv */
// shared types, constants and state codes for the polyline nearest distance block
// no dependencies
package pnd_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 24;
    localparam int VERT_W       = 2 * COORD_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int MUL_W        = 27;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = 52;
    localparam int SQ_W         = 51;
    localparam int ARG_W        = 2 * SQ_W;
    localparam int DIST_W       = 25;
    localparam int NORM_W       = 16;
    localparam int FQ_DEPTH     = 4;
    localparam int FQ_PTR_W     = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W     = $clog2(FQ_DEPTH + 1);
    localparam int ROOT_STEP_W  = 6;
    localparam int ROOT_DIV_STEPS  = SQ_W;
    localparam int ROOT_SQRT_STEPS = 26;
    localparam int MSTEP_LAST   = 10;
    localparam int SQSTEP_LAST  = 3;
    localparam logic [COORD_W-1:0] DIST_SAT = {COORD_W{1'b1}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      first_vertex;
    } in_item_t;

    typedef struct packed {
        logic        [COORD_W-1:0] distance;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic                      no_path;
        logic                      overflowed;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_RESTART,
        CMD_QUERY
    } cmd_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } fq_entry_t;

    typedef enum logic {
        ROOT_DIV,
        ROOT_SQRT
    } root_op_t;

    typedef struct packed {
        logic     start;
        root_op_t op;
    } root_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_FETCH,
        B_GETV,
        B_DIFF,
        B_MUL,
        B_VROOT,
        B_VWAIT,
        B_SEGCHK,
        B_SQ,
        B_SDIV,
        B_SDWAIT,
        B_SROOT,
        B_SRWAIT,
        B_NEXT,
        B_NPICK,
        B_NMUL,
        B_NDIV,
        B_NDWAIT,
        B_NROOT,
        B_NRWAIT,
        B_NSTORE,
        B_OUT
    } back_state_t;

endpackage

/* rtl/pnd_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pnd_front.sv */
// front end: accepts input items, classifies them and queues them for the back end
// depends on pnd_pkg
module pnd_front
    import pnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      deq,
    output logic      fq_valid,
    output fq_entry_t fq_head
);

    fq_entry_t             mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   wr_reg, wr_next;
    logic [FQ_PTR_W-1:0]   rd_reg, rd_next;
    logic [FQ_CNT_W-1:0]   cnt_reg, cnt_next;
    fq_entry_t             entry;
    logic                  do_push;
    logic                  do_pop;

    always_comb
    begin
        entry.x = item.point_x;
        entry.y = item.point_y;
        if (item.op == OP_QUERY)
        begin
            entry.cmd = CMD_QUERY;
        end
        else if (item.first_vertex)
        begin
            entry.cmd = CMD_RESTART;
        end
        else
        begin
            entry.cmd = CMD_LOAD;
        end
    end

    assign full     = (cnt_reg == FQ_CNT_W'(FQ_DEPTH));
    assign fq_valid = (cnt_reg != '0);
    assign fq_head  = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = deq && fq_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= entry;
        end
    end

endmodule

/* rtl/pnd_root.sv */
// shared iterative unit: restoring division (one quotient bit a cycle)
// and integer square root (one root bit a cycle); depends on pnd_pkg
module pnd_root
    import pnd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  root_req_t        req,
    input  logic [ARG_W-1:0] arg,
    input  logic [SQ_W-1:0]  divisor,
    output root_stat_t       stat,
    output logic [SQ_W-1:0]  res
);

    logic                   busy_reg;
    logic                   done_reg;
    root_op_t               op_reg;
    logic [ROOT_STEP_W-1:0] step_reg;
    logic [SQ_W:0]          rem_reg;
    logic [SQ_W:0]          lo_reg;
    logic [SQ_W-1:0]        res_reg;
    logic [SQ_W-1:0]        div_reg;
    logic [SQ_W:0]          rem2;
    logic [SQ_W:0]          trial;
    logic [SQ_W:0]          lo_shift;
    logic                   ge;

    always_comb
    begin
        if (op_reg == ROOT_DIV)
        begin
            rem2     = {rem_reg[SQ_W-1:0], lo_reg[SQ_W]};
            trial    = {1'b0, div_reg};
            lo_shift = {lo_reg[SQ_W-1:0], 1'b0};
        end
        else
        begin
            rem2     = {rem_reg[SQ_W-2:0], lo_reg[SQ_W:SQ_W-1]};
            trial    = {res_reg[SQ_W-2:0], 2'b01};
            lo_shift = {lo_reg[SQ_W-2:0], 2'b00};
        end
        ge = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ROOT_DIV;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                step_reg <= (req.op == ROOT_DIV) ? ROOT_STEP_W'(ROOT_DIV_STEPS - 1)
                                                 : ROOT_STEP_W'(ROOT_SQRT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            res_reg <= '0;
            div_reg <= divisor;
            if (req.op == ROOT_DIV)
            begin
                // callers guarantee the quotient fits, so the top half is below the divisor
                rem_reg <= {1'b0, arg[ARG_W-1:SQ_W]};
                lo_reg  <= {arg[SQ_W-1:0], 1'b0};
            end
            else
            begin
                rem_reg <= '0;
                lo_reg  <= {1'b0, arg[SQ_W-1:0]};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem2 - trial : rem2;
            lo_reg  <= lo_shift;
            res_reg <= {res_reg[SQ_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = res_reg;

endmodule

/* rtl/pnd_back.sv */
// back end: vertex store, query scan sequencer, shared multiplier and result register
// depends on pnd_pkg, pnd_ram and pnd_root
module pnd_back
    import pnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fq_valid,
    input  fq_entry_t fq_head,
    output logic      deq,
    input  logic      pop,
    output out_item_t result,
    output logic      res_valid
);

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]            cnt_reg;
    logic                        ovf_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic signed [COORD_W-1:0]   qx_reg, qy_reg;
    logic signed [COORD_W-1:0]   ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DIFF_W-1:0]    dx_reg, dy_reg, wax_reg, way_reg, wbx_reg, wby_reg;
    logic [3:0]                  mstep_reg;
    logic [1:0]                  sqstep_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [SQ_W-1:0]             vd_reg;
    logic signed [ACC_W-1:0]     dot1_reg, dot2_reg, c_reg;
    logic [SQ_W-1:0]             dsq_reg;
    logic [ARG_W-1:0]            csq_reg;
    logic                        vhave_reg, shave_reg;
    logic [DIST_W-1:0]           vbest_reg, sbest_reg;
    logic signed [DIFF_W-1:0]    vnx_reg, vny_reg, snx_reg, sny_reg;
    logic [SQ_W-1:0]             vdsq_reg, sdsq_reg;
    logic                        sneg_reg;
    logic                        win_seg_reg;
    logic                        nsel_reg;
    logic                        nopath_reg;
    logic signed [NORM_W-1:0]    nx_reg, ny_reg;
    logic                        res_valid_reg;
    out_item_t                   result_reg;

    logic                        ram_we, ram_re;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [VERT_W-1:0]           ram_rdata;
    logic [CNT_W-1:0]            cnt_eff;
    logic                        load_drop;
    root_req_t                   root_req;
    root_stat_t                  root_stat;
    logic [ARG_W-1:0]            root_arg;
    logic [SQ_W-1:0]             root_div;
    logic [SQ_W-1:0]             root_res;
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic [ACC_W-1:0]            cmag;
    logic                        seg_ok;
    logic                        seg_win;
    logic signed [DIFF_W-1:0]    ncomp;
    logic [NORM_W:0]             rnd;
    logic signed [NORM_W-1:0]    nval;
    logic                        out_free;
    logic [DIST_W-1:0]           best;

    pnd_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({fq_head.x, fq_head.y}),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    pnd_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (root_req),
        .arg     (root_arg),
        .divisor (root_div),
        .stat    (root_stat),
        .res     (root_res)
    );

    // combinational helpers
    always_comb
    begin
        cnt_eff   = (fq_head.cmd == CMD_RESTART) ? '0 : cnt_reg;
        load_drop = (cnt_eff >= CNT_W'(MAX_VERTICES));
        cmag      = c_reg[ACC_W-1] ? ACC_W'(-c_reg) : ACC_W'(c_reg);
        seg_ok    = (idx_reg != '0) && !dot1_reg[ACC_W-1]
                    && (dot2_reg[ACC_W-1] || dot2_reg == '0) && (dsq_reg != '0);
        seg_win   = shave_reg && (!vhave_reg || sbest_reg <= vbest_reg);
        if (nsel_reg == 1'b0)
        begin
            ncomp = win_seg_reg ? snx_reg : vnx_reg;
        end
        else
        begin
            ncomp = win_seg_reg ? sny_reg : vny_reg;
        end
        // round half up in magnitude
        rnd       = {1'b0, root_res[NORM_W-1:0]} + 1'b1;
        nval      = (ncomp[DIFF_W-1] ^ (win_seg_reg & sneg_reg))
                    ? -$signed(rnd[NORM_W:1]) : $signed(rnd[NORM_W:1]);
        out_free  = !res_valid_reg || pop;
        best      = win_seg_reg ? sbest_reg : vbest_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (fq_valid && fq_head.cmd == CMD_QUERY)
                begin
                    state_next = (cnt_reg == '0) ? B_OUT : B_FETCH;
                end
            end
            B_FETCH:  state_next = B_GETV;
            B_GETV:   state_next = B_DIFF;
            B_DIFF:   state_next = B_MUL;
            B_MUL:
            begin
                if (mstep_reg == 4'(MSTEP_LAST))
                begin
                    state_next = B_VROOT;
                end
            end
            B_VROOT:  state_next = B_VWAIT;
            B_VWAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_SEGCHK;
                end
            end
            B_SEGCHK: state_next = seg_ok ? B_SQ : B_NEXT;
            B_SQ:
            begin
                if (sqstep_reg == 2'(SQSTEP_LAST))
                begin
                    state_next = B_SDIV;
                end
            end
            B_SDIV:   state_next = B_SDWAIT;
            B_SDWAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_SROOT;
                end
            end
            B_SROOT:  state_next = B_SRWAIT;
            B_SRWAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_NEXT;
                end
            end
            B_NEXT:   state_next = (idx_reg + 1'b1 < cnt_reg) ? B_FETCH : B_NPICK;
            B_NPICK:  state_next = (!seg_win && vdsq_reg == '0) ? B_OUT : B_NMUL;
            B_NMUL:   state_next = B_NDIV;
            B_NDIV:   state_next = B_NDWAIT;
            B_NDWAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_NROOT;
                end
            end
            B_NROOT:  state_next = B_NRWAIT;
            B_NRWAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = B_NSTORE;
                end
            end
            B_NSTORE: state_next = nsel_reg ? B_OUT : B_NMUL;
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        deq          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_eff[ADDR_W-1:0];
        ram_re       = 1'b0;
        root_req     = '{start: 1'b0, op: ROOT_SQRT};
        root_arg     = {{(ARG_W-SQ_W){1'b0}}, vd_reg};
        root_div     = dsq_reg;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            B_IDLE:
            begin
                deq    = fq_valid;
                ram_we = fq_valid && (fq_head.cmd != CMD_QUERY) && !load_drop;
            end
            B_FETCH:
            begin
                ram_re = 1'b1;
            end
            B_MUL:
            begin
                case (mstep_reg)
                    4'd0:    begin mul_a = MUL_W'(wbx_reg); mul_b = MUL_W'(wbx_reg); end
                    4'd1:    begin mul_a = MUL_W'(wby_reg); mul_b = MUL_W'(wby_reg); end
                    4'd2:    begin mul_a = MUL_W'(wax_reg); mul_b = MUL_W'(dx_reg);  end
                    4'd3:    begin mul_a = MUL_W'(way_reg); mul_b = MUL_W'(dy_reg);  end
                    4'd4:    begin mul_a = MUL_W'(wbx_reg); mul_b = MUL_W'(dx_reg);  end
                    4'd5:    begin mul_a = MUL_W'(wby_reg); mul_b = MUL_W'(dy_reg);  end
                    4'd6:    begin mul_a = MUL_W'(dx_reg);  mul_b = MUL_W'(dx_reg);  end
                    4'd7:    begin mul_a = MUL_W'(dy_reg);  mul_b = MUL_W'(dy_reg);  end
                    4'd8:    begin mul_a = MUL_W'(dx_reg);  mul_b = MUL_W'(way_reg); end
                    4'd9:    begin mul_a = MUL_W'(dy_reg);  mul_b = MUL_W'(wax_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            B_SQ:
            begin
                // |c| squared from two 26-bit halves
                case (sqstep_reg)
                    2'd0:    begin mul_a = {1'b0, cmag[51:26]}; mul_b = {1'b0, cmag[51:26]}; end
                    2'd1:    begin mul_a = {1'b0, cmag[51:26]}; mul_b = {1'b0, cmag[25:0]};  end
                    2'd2:    begin mul_a = {1'b0, cmag[25:0]};  mul_b = {1'b0, cmag[25:0]};  end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            B_VROOT:
            begin
                root_req = '{start: 1'b1, op: ROOT_SQRT};
            end
            B_SDIV:
            begin
                root_req = '{start: 1'b1, op: ROOT_DIV};
                root_arg = csq_reg;
            end
            B_SROOT:
            begin
                root_req = '{start: 1'b1, op: ROOT_SQRT};
                root_arg = {{(ARG_W-SQ_W){1'b0}}, root_res};
            end
            B_NMUL:
            begin
                mul_a = MUL_W'(ncomp);
                mul_b = MUL_W'(ncomp);
            end
            B_NDIV:
            begin
                // comp squared scaled by 2^30 over |d| squared
                root_req = '{start: 1'b1, op: ROOT_DIV};
                root_arg = {24'b0, prod_reg[47:0], 30'b0};
                root_div = win_seg_reg ? sdsq_reg : vdsq_reg;
            end
            B_NROOT:
            begin
                root_req = '{start: 1'b1, op: ROOT_SQRT};
                root_arg = {{(ARG_W-SQ_W){1'b0}}, root_res};
            end
            default:
            begin
                deq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && fq_valid && fq_head.cmd != CMD_QUERY)
            begin
                if (load_drop)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_eff + 1'b1;
                end
            end
            if (state_reg == B_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            B_IDLE:
            begin
                qx_reg     <= fq_head.x;
                qy_reg     <= fq_head.y;
                idx_reg    <= '0;
                vhave_reg  <= 1'b0;
                shave_reg  <= 1'b0;
                nopath_reg <= (cnt_reg == '0);
                nsel_reg   <= 1'b0;
            end
            B_GETV:
            begin
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
                bx_reg <= ram_rdata[VERT_W-1:COORD_W];
                by_reg <= ram_rdata[COORD_W-1:0];
            end
            B_DIFF:
            begin
                dx_reg    <= DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
                dy_reg    <= DIFF_W'(by_reg) - DIFF_W'(ay_reg);
                wax_reg   <= DIFF_W'(qx_reg) - DIFF_W'(ax_reg);
                way_reg   <= DIFF_W'(qy_reg) - DIFF_W'(ay_reg);
                wbx_reg   <= DIFF_W'(qx_reg) - DIFF_W'(bx_reg);
                wby_reg   <= DIFF_W'(qy_reg) - DIFF_W'(by_reg);
                mstep_reg <= '0;
            end
            B_MUL:
            begin
                mstep_reg <= mstep_reg + 1'b1;
                // each step takes the product launched one step earlier
                case (mstep_reg)
                    4'd1:    vd_reg   <= prod_reg[SQ_W-1:0];
                    4'd2:    vd_reg   <= vd_reg + prod_reg[SQ_W-1:0];
                    4'd3:    dot1_reg <= prod_reg[ACC_W-1:0];
                    4'd4:    dot1_reg <= dot1_reg + prod_reg[ACC_W-1:0];
                    4'd5:    dot2_reg <= prod_reg[ACC_W-1:0];
                    4'd6:    dot2_reg <= dot2_reg + prod_reg[ACC_W-1:0];
                    4'd7:    dsq_reg  <= prod_reg[SQ_W-1:0];
                    4'd8:    dsq_reg  <= dsq_reg + prod_reg[SQ_W-1:0];
                    4'd9:    c_reg    <= prod_reg[ACC_W-1:0];
                    4'd10:   c_reg    <= c_reg - prod_reg[ACC_W-1:0];
                    default: c_reg    <= c_reg;
                endcase
            end
            B_VWAIT:
            begin
                if (root_stat.done && (!vhave_reg || root_res[DIST_W-1:0] < vbest_reg))
                begin
                    vhave_reg <= 1'b1;
                    vbest_reg <= root_res[DIST_W-1:0];
                    vnx_reg   <= wbx_reg;
                    vny_reg   <= wby_reg;
                    vdsq_reg  <= vd_reg;
                end
                sqstep_reg <= '0;
            end
            B_SQ:
            begin
                sqstep_reg <= sqstep_reg + 1'b1;
                case (sqstep_reg)
                    2'd1:    csq_reg <= {prod_reg[49:0], 52'b0};
                    2'd2:    csq_reg <= csq_reg + {24'b0, prod_reg[50:0], 27'b0};
                    2'd3:    csq_reg <= csq_reg + {50'b0, prod_reg[51:0]};
                    default: csq_reg <= csq_reg;
                endcase
            end
            B_SRWAIT:
            begin
                if (root_stat.done && (!shave_reg || root_res[DIST_W-1:0] < sbest_reg))
                begin
                    shave_reg <= 1'b1;
                    sbest_reg <= root_res[DIST_W-1:0];
                    snx_reg   <= -dy_reg;
                    sny_reg   <= dx_reg;
                    sdsq_reg  <= dsq_reg;
                    sneg_reg  <= c_reg[ACC_W-1];
                end
            end
            B_NEXT:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            B_NPICK:
            begin
                win_seg_reg <= seg_win;
                nx_reg      <= '0;
                ny_reg      <= '0;
            end
            B_NSTORE:
            begin
                nsel_reg <= 1'b1;
                if (nsel_reg)
                begin
                    ny_reg <= nval;
                end
                else
                begin
                    nx_reg <= nval;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    result_reg.no_path    <= nopath_reg;
                    result_reg.overflowed <= ovf_reg;
                    if (nopath_reg)
                    begin
                        result_reg.distance <= DIST_SAT;
                        result_reg.normal_x <= '0;
                        result_reg.normal_y <= '0;
                    end
                    else
                    begin
                        result_reg.distance <= best[DIST_W-1] ? DIST_SAT : best[COORD_W-1:0];
                        result_reg.normal_x <= nx_reg;
                        result_reg.normal_y <= ny_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result    = result_reg;
    assign res_valid = res_valid_reg;

endmodule

/* rtl/polyline_nearest_distance.sv */
// Nearest distance from a query point to a stored polyline, with the unit normal
// toward the point. Load items are taken straight from the queue while the back end
// is idle; a query visits every stored vertex once and takes a square root on the
// shared divide and square root unit (one result bit per cycle) for it, adding a
// divide and a second root when the point projects onto the segment ending there,
// and, when a normal is needed, ends with a divide and a root for each component.
// A four-entry queue in front and a result register behind let input and output
// run while a query is in progress. The vertex store holds 1024 entries.
`include "polyline_nearest_distance_defines.svh"
module polyline_nearest_distance
    import pnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic      fq_valid;
    fq_entry_t fq_head;
    logic      deq;
    logic      res_valid;

    pnd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .deq      (deq),
        .fq_valid (fq_valid),
        .fq_head  (fq_head)
    );

    pnd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fq_valid  (fq_valid),
        .fq_head   (fq_head),
        .deq       (deq),
        .pop       (pop),
        .result    (result),
        .res_valid (res_valid)
    );

    assign empty = !res_valid;

    `PND_ASSERT_SAME(a_nopath_sat, !empty && result.no_path, result.distance == DIST_SAT && result.normal_x == '0 && result.normal_y == '0)
    `PND_ASSERT_SAME(a_norm_x_range, !empty, $signed(result.normal_x) >= -16'sd16384 && $signed(result.normal_x) <= 16'sd16384)
    `PND_ASSERT_SAME(a_norm_y_range, !empty, $signed(result.normal_y) >= -16'sd16384 && $signed(result.normal_y) <= 16'sd16384)
    `PND_ASSERT_NEXT(a_ovf_sticky, !empty && pop && result.overflowed, empty || result.overflowed)

endmodule

/* test/tb.sv */
// self-checking testbench for polyline_nearest_distance: vertex loads and
// nearest-distance queries checked against an integer predictor
// depends on pnd_pkg and the polyline_nearest_distance top level
module tb;
    import pnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 3000;
    localparam int HOLD_CYCLES = 4000;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;

    typedef struct {
        logic      op;
        int        x;
        int        y;
        logic      first;
        bit        typed;
        out_item_t answer;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    // predictor state
    longint path_x[MAX_VERTICES];
    longint path_y[MAX_VERTICES];
    int     path_len;
    bit     path_dropped;

    out_item_t answer_q[$];
    int        errors;
    int        cycles;
    int        tx_idle;
    int        rx_idle;
    logic      rx_hold;
    bit        hold_go;
    int        loads_sent;
    int        queries_sent;
    int        answers_seen;

    polyline_nearest_distance i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // largest q with q*q*den <= num*num
    function automatic bit [63:0] root_ratio(bit [127:0] num, bit [127:0] den, int top);
        bit [127:0] target;
        bit [127:0] t;
        bit [63:0]  q;
        int         i;
        target = num * num;
        q = '0;
        for (i = top; i >= 0; i--)
        begin
            t = {64'd0, q} | (128'd1 << i);
            if (t * t * den <= target)
                q = t[63:0];
        end
        return q;
    endfunction

    function automatic longint unit_comp(longint comp, bit [127:0] dsq);
        bit [127:0] mag;
        longint     r;
        mag = (comp < 0) ? 128'(-comp) : 128'(comp);
        r = longint'((root_ratio(mag * 128'd32768, dsq, 15) + 64'd1) >> 1);
        return (comp < 0) ? -r : r;
    endfunction

    function automatic bit [63:0] isqrt(longint n);
        bit [63:0] q;
        bit [63:0] t;
        int        i;
        q = '0;
        for (i = 31; i >= 0; i--)
        begin
            t = q | (64'd1 << i);
            if (t * t <= 64'(n))
                q = t;
        end
        return q;
    endfunction

    function automatic void predict_item(in_item_t it, output bit has, output out_item_t res);
        longint     vx;
        longint     vy;
        longint     dx;
        longint     dy;
        longint     wx;
        longint     wy;
        longint     c;
        longint     dsq;
        longint     nx;
        longint     ny;
        bit [63:0]  best;
        bit [63:0]  d;
        bit         found;
        int         p;
        vx = longint'(it.point_x);
        vy = longint'(it.point_y);
        has = 1'b0;
        res = '0;
        if (it.op == OP_LOAD)
        begin
            if (it.first_vertex)
                path_len = 0;
            if (path_len >= MAX_VERTICES)
                path_dropped = 1'b1;
            else
            begin
                path_x[path_len] = vx;
                path_y[path_len] = vy;
                path_len++;
            end
            return;
        end
        found = 1'b0;
        best = '0;
        nx = 0;
        ny = 0;
        for (p = 0; p + 1 < path_len; p++)
        begin
            dx = path_x[p+1] - path_x[p];
            dy = path_y[p+1] - path_y[p];
            wx = vx - path_x[p];
            wy = vy - path_y[p];
            // only if the point projects inside the segment
            if (wx * dx + wy * dy < 0)
                continue;
            if ((vx - path_x[p+1]) * dx + (vy - path_y[p+1]) * dy > 0)
                continue;
            dsq = dx * dx + dy * dy;
            if (dsq == 0)
                continue;
            c = dx * wy - dy * wx;
            d = root_ratio((c < 0) ? 128'(-c) : 128'(c), 128'(dsq), 26);
            if (!found || d < best)
            begin
                found = 1'b1;
                best = d;
                nx = unit_comp(-dy, 128'(dsq));
                ny = unit_comp(dx, 128'(dsq));
                if (c < 0)
                begin
                    nx = -nx;
                    ny = -ny;
                end
            end
        end
        for (p = 0; p < path_len; p++)
        begin
            wx = vx - path_x[p];
            wy = vy - path_y[p];
            dsq = wx * wx + wy * wy;
            d = isqrt(dsq);
            if (!found || d < best)
            begin
                found = 1'b1;
                best = d;
                if (dsq == 0)
                begin
                    nx = 0;
                    ny = 0;
                end
                else
                begin
                    nx = unit_comp(wx, 128'(dsq));
                    ny = unit_comp(wy, 128'(dsq));
                end
            end
        end
        has = 1'b1;
        res.distance = (!found || best > 64'hFFFFFF) ? DIST_SAT : best[COORD_W-1:0];
        res.normal_x = nx[NORM_W-1:0];
        res.normal_y = ny[NORM_W-1:0];
        res.no_path = (path_len == 0);
        res.overflowed = path_dropped;
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t typed_answer);
        bit        has;
        out_item_t res;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(it, has, res);
        if (it.op == OP_LOAD)
            loads_sent++;
        else
            queries_sent++;
        if (has)
            answer_q.push_back(typed ? typed_answer : res);
    endtask

    function automatic in_item_t make_item(logic op, int x, int y, logic first);
        in_item_t it;
        it.op = op;
        it.point_x = x[COORD_W-1:0];
        it.point_y = y[COORD_W-1:0];
        it.first_vertex = first;
        return it;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 4) == 0)
            return int'($urandom_range(0, 24'hFFFFFF)) - 24'h800000;
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    task automatic send_rand(logic op, logic first);
        out_item_t none;
        none = '0;
        send_item(make_item(op, rand_coord(), rand_coord(), first), 1'b0, none);
    endtask

    // fresh random paths, each then followed by a few random queries, with stray random items mixed in
    task automatic random_burst(int target);
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_rand(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                n = $urandom_range(1, 7);
                send_rand(OP_LOAD, 1'b1);
                for (k = 1; k < n; k++)
                    send_rand(OP_LOAD, 1'b0);
                sent += n;
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_rand(OP_QUERY, 1'($urandom_range(0, 1)));
                sent += n;
            end
        end
    endtask

    task automatic drain();
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: pops at random, checks every item against the oldest answer
    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                answers_seen++;
                if (answer_q.size() == 0)
                begin
                    $display("unexpected result item at cycle %0d", cycles);
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (result.distance !== want.distance)
                        report_mismatch("distance", result.distance, want.distance);
                    if (result.normal_x !== want.normal_x)
                        report_mismatch("normal_x", result.normal_x, want.normal_x);
                    if (result.normal_y !== want.normal_y)
                        report_mismatch("normal_y", result.normal_y, want.normal_y);
                    if (result.no_path !== want.no_path)
                        report_mismatch("no_path", result.no_path, want.no_path);
                    if (result.overflowed !== want.overflowed)
                        report_mismatch("overflowed", result.overflowed, want.overflowed);
                end
            end
            pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        int        i;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        hold_go = 1'b0;
        errors = 0;
        path_len = 0;
        path_dropped = 1'b0;
        loads_sent = 0;
        queries_sent = 0;
        answers_seen = 0;
        tx_idle = 24;
        rx_idle = 49;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        r = '{OP_QUERY, 0, 0, 1'b0, 1'b1, '{DIST_SAT, 16'sd0, 16'sd0, 1'b1, 1'b0}};
        rows.push_back(r);
        r = '{OP_LOAD, 0, 0, 1'b1, 1'b0, '0};
        rows.push_back(r);
        // point on a vertex
        r = '{OP_QUERY, 0, 0, 1'b0, 1'b1, '{24'd0, 16'sd0, 16'sd0, 1'b0, 1'b0}};
        rows.push_back(r);
        r = '{OP_QUERY, 256, 0, 1'b1, 1'b1, '{24'd256, 16'sd16384, 16'sd0, 1'b0, 1'b0}};
        rows.push_back(r);
        r = '{OP_LOAD, 1024, 0, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, 512, 300, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, 512, -300, 1'b0, 1'b0, '0};
        rows.push_back(r);
        // point on the segment line
        r = '{OP_QUERY, 512, 0, 1'b0, 1'b1, '{24'd0, 16'sd0, 16'sd16384, 1'b0, 1'b0}};
        rows.push_back(r);
        r = '{OP_QUERY, 2000, 100, 1'b0, 1'b0, '0};
        rows.push_back(r);
        // zero-length segment
        r = '{OP_LOAD, 1024, 0, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_LOAD, 1024, 2048, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, 1100, 1000, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, 1024, 0, 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_LOAD, int'(signed'(COORD_MIN)), int'(signed'(COORD_MIN)), 1'b1, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_LOAD, int'(COORD_MAX), int'(COORD_MAX), 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, int'(COORD_MAX), int'(signed'(COORD_MIN)), 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, int'(signed'(COORD_MIN)), int'(COORD_MAX), 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, int'(COORD_MAX), int'(COORD_MAX), 1'b0, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_LOAD, int'(COORD_MAX), int'(signed'(COORD_MIN)), 1'b1, 1'b0, '0};
        rows.push_back(r);
        r = '{OP_QUERY, int'(signed'(COORD_MIN)), int'(COORD_MAX), 1'b0, 1'b0, '0};
        rows.push_back(r);
        for (i = 0; i < rows.size(); i++)
            send_item(make_item(rows[i].op, rows[i].x, rows[i].y, rows[i].first),
                      rows[i].typed, rows[i].answer);
        push <= 1'b0;
        drain();

        random_burst(90);
        push <= 1'b0;
        drain();

        tx_idle = 49;
        rx_idle = 24;
        random_burst(90);
        push <= 1'b0;
        drain();

        tx_idle = 0;
        rx_idle = 0;
        hold_go = 1'b1;
        random_burst(90);
        push <= 1'b0;
        drain();

        if (answer_q.size() != 0)
        begin
            $display("%0d result items never arrived", answer_q.size());
            errors++;
        end
        $display("covered %0d loads and %0d queries, %0d results checked", loads_sent,
                 queries_sent, answers_seen);
        $display("edge cases, three idle mixes and a long receiver stall with a full input");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* polyline_nearest_distance.f */
+incdir+rtl
rtl/pnd_pkg.sv
rtl/pnd_ram.sv
rtl/pnd_front.sv
rtl/pnd_root.sv
rtl/pnd_back.sv
rtl/polyline_nearest_distance.sv
test/tb.sv
